// ===== rtl/xxh_pkg.sv =====
package xxh_pkg;

    localparam int SEED_LANES = 4;
    localparam int MAX_LANES  = 4;

    localparam logic [31:0] PRIME_A = 32'h9E37_79B1;
    localparam logic [31:0] PRIME_B = 32'h85EB_CA77;
    localparam logic [31:0] PRIME_C = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME_D = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME_E = 32'h1656_67B1;

    localparam logic [31:0] SEED0_RST = 32'h1234_5678;
    localparam logic [31:0] SEED1_RST = 32'h9ABC_DEF0;
    localparam logic [31:0] SEED2_RST = 32'h1357_9BDF;
    localparam logic [31:0] SEED3_RST = 32'h2468_ACE0;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_MULB  = 4'd2,
        OP_MULC  = 4'd3,
        OP_MULE  = 4'd4,
        OP_ACC   = 4'd5,
        OP_FOLDW = 4'd6,
        OP_FOLDB = 4'd7,
        OP_INIT  = 4'd8,
        OP_AV1   = 4'd9,
        OP_AV2   = 4'd10
    } lane_op_t;

    typedef struct packed {
        lane_op_t    op;
        logic [1:0]  kidx;
        logic [31:0] operand;
        logic        seen;
        logic [31:0] len;
    } lane_cmd_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== rtl/multi_seed_xxh32_hash_unit.sv =====
// a buffered word is just stored; a word that completes a stripe runs accept, seed load
// (first stripe only), then a multiply and a round for each of the 4 accumulators
// last word: after its stripe work, init, then a multiply and a fold per leftover word
// and byte, then avalanche AV1 and AV2; input is taken again once the digests are stored
// throughput: one item at a time, set by the single multiplier in each lane
// reset (rst_n low, asynchronous) restores the seed reset values and clears message state
module multi_seed_xxh32_hash_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // data_word[31:0], bytes_valid[34:32], zero pad
    input  logic         s_tlast,   // last_word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // digest_zero, digest_one, digest_two, digest_three
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_SROUND = 9'b000000100,
        S_FINIT  = 9'b000001000,
        S_FWORD  = 9'b000010000,
        S_FBYTE  = 9'b000100000,
        S_AV1    = 9'b001000000,
        S_AV2    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] seed_reg [4];
    logic [31:0] pend_reg [3];
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [31:0] len_reg, len_next;
    logic        seen_reg, seen_next;
    logic [31:0] word_reg;
    logic [2:0]  nb_reg;
    logic        wpend_reg;
    logic        fin_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        half_reg, half_next;
    logic        mvalid_reg;
    logic [127:0] mdata_reg;

    logic [31:0] in_word;
    logic [2:0]  in_nb;
    logic        accept;
    logic        full_word;
    logic [1:0]  nwords;
    logic [31:0] sel_word;
    logic [7:0]  sel_byte;
    logic        out_free;
    xxh_pkg::lane_cmd_t cmd;
    logic [31:0] digest [4];

    assign in_word   = s_tdata[31:0];
    assign in_nb     = (!s_tlast || s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full_word = (in_nb == 3'd4);
    assign cfg_ready = 1'b1;
    assign out_free  = !mvalid_reg || m_tready;
    assign nwords    = pcnt_reg + {1'b0, wpend_reg};
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_word = pend_reg[0];
            2'd1:    sel_word = pend_reg[1];
            2'd2:    sel_word = pend_reg[2];
            default: sel_word = word_reg;
        endcase
        // leftover full word sits after the buffered ones
        if (state_reg == S_FWORD && idx_reg == pcnt_reg)
            sel_word = word_reg;
        else if (state_reg == S_SROUND && idx_reg == 2'd3)
            sel_word = word_reg;
        case (idx_reg)
            2'd0:    sel_byte = word_reg[7:0];
            2'd1:    sel_byte = word_reg[15:8];
            2'd2:    sel_byte = word_reg[23:16];
            default: sel_byte = word_reg[31:24];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pcnt_next  = pcnt_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        idx_next   = idx_reg;
        half_next  = half_reg;
        cmd.op      = xxh_pkg::OP_NONE;
        cmd.kidx    = idx_reg;
        cmd.operand = sel_word;
        cmd.seen    = seen_reg;
        cmd.len     = len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    len_next = len_reg + {29'd0, in_nb};
                    if (full_word && pcnt_reg == 2'd3)
                        state_next = S_LOAD;
                    else if (s_tlast)
                        state_next = S_FINIT;
                    else
                        pcnt_next = pcnt_reg + 2'd1;
                end
                idx_next  = 2'd0;
                half_next = 1'b0;
            end
            S_LOAD:
            begin
                if (!seen_reg)
                    cmd.op = xxh_pkg::OP_LOAD;
                state_next = S_SROUND;
            end
            S_SROUND:
            begin
                cmd.op    = half_reg ? xxh_pkg::OP_ACC : xxh_pkg::OP_MULB;
                half_next = !half_reg;
                if (half_reg)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        seen_next  = 1'b1;
                        pcnt_next  = 2'd0;
                        state_next = fin_reg ? S_FINIT : S_IDLE;
                    end
                end
            end
            S_FINIT:
            begin
                cmd.op    = xxh_pkg::OP_INIT;
                idx_next  = 2'd0;
                half_next = 1'b0;
                if (nwords != 2'd0)
                    state_next = S_FWORD;
                else if (nb_reg != 3'd4 && nb_reg != 3'd0)
                    state_next = S_FBYTE;
                else
                    state_next = S_AV1;
            end
            S_FWORD:
            begin
                cmd.op    = half_reg ? xxh_pkg::OP_FOLDW : xxh_pkg::OP_MULC;
                half_next = !half_reg;
                if (half_reg)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg + 2'd1 == nwords)
                    begin
                        idx_next = 2'd0;
                        if (nb_reg != 3'd4 && nb_reg != 3'd0)
                            state_next = S_FBYTE;
                        else
                            state_next = S_AV1;
                    end
                end
            end
            S_FBYTE:
            begin
                cmd.op      = half_reg ? xxh_pkg::OP_FOLDB : xxh_pkg::OP_MULE;
                cmd.operand = {24'd0, sel_byte};
                half_next   = !half_reg;
                if (half_reg)
                begin
                    idx_next = idx_reg + 2'd1;
                    if ({1'b0, idx_reg} + 3'd1 == nb_reg)
                        state_next = S_AV1;
                end
            end
            S_AV1:
            begin
                cmd.op     = xxh_pkg::OP_AV1;
                state_next = S_AV2;
            end
            S_AV2:
            begin
                cmd.op     = xxh_pkg::OP_AV2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    pcnt_next  = 2'd0;
                    len_next   = 32'd0;
                    seen_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pcnt_reg    <= 2'd0;
            len_reg     <= 32'd0;
            seen_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            half_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
            seed_reg[0] <= xxh_pkg::SEED0_RST;
            seed_reg[1] <= xxh_pkg::SEED1_RST;
            seed_reg[2] <= xxh_pkg::SEED2_RST;
            seed_reg[3] <= xxh_pkg::SEED3_RST;
        end
        else
        begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
            if (cfg_valid)
                seed_reg[cfg_index] <= cfg_data;
            if (state_reg == S_OUT && out_free)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= in_word;
            nb_reg    <= in_nb;
            fin_reg   <= s_tlast;
            wpend_reg <= s_tlast && full_word && pcnt_reg != 2'd3;
            if (full_word && pcnt_reg != 2'd3 && !s_tlast)
                pend_reg[pcnt_reg] <= in_word;
        end
        if (state_reg == S_OUT && out_free)
            mdata_reg <= {digest[3], digest[2], digest[1], digest[0]};
    end

    for (genvar l = 0; l < xxh_pkg::MAX_LANES; l++)
    begin : g_lane
        if (l < xxh_pkg::SEED_LANES)
        begin : g_on
            xxh_lane u_lane
            (
                .clk    (clk),
                .seed   (seed_reg[l]),
                .cmd    (cmd),
                .digest (digest[l])
            );
        end
        else
        begin : g_off
            assign digest[l] = 32'd0;
        end
    end

endmodule

// ===== rtl/xxh_lane.sv =====
module xxh_lane
(
    input  logic                clk,
    input  logic [31:0]         seed,
    input  xxh_pkg::lane_cmd_t  cmd,
    output logic [31:0]         digest
);

    logic [31:0] acc_reg [4];
    logic [31:0] prod_reg;
    logic [31:0] h_reg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] prod;
    logic [31:0] base;

    always_comb
    begin
        ma = cmd.operand;
        mb = xxh_pkg::PRIME_B;
        case (cmd.op)
            xxh_pkg::OP_MULB:
            begin
                ma = cmd.operand;
                mb = xxh_pkg::PRIME_B;
            end
            xxh_pkg::OP_MULC:
            begin
                ma = cmd.operand;
                mb = xxh_pkg::PRIME_C;
            end
            xxh_pkg::OP_MULE:
            begin
                ma = cmd.operand;
                mb = xxh_pkg::PRIME_E;
            end
            xxh_pkg::OP_ACC:
            begin
                ma = xxh_pkg::rotl(acc_reg[cmd.kidx] + prod_reg, 13);
                mb = xxh_pkg::PRIME_A;
            end
            xxh_pkg::OP_FOLDW:
            begin
                ma = xxh_pkg::rotl(h_reg + prod_reg, 17);
                mb = xxh_pkg::PRIME_D;
            end
            xxh_pkg::OP_FOLDB:
            begin
                ma = xxh_pkg::rotl(h_reg + prod_reg, 11);
                mb = xxh_pkg::PRIME_A;
            end
            xxh_pkg::OP_AV1:
            begin
                ma = h_reg ^ (h_reg >> 15);
                mb = xxh_pkg::PRIME_B;
            end
            xxh_pkg::OP_AV2:
            begin
                ma = h_reg ^ (h_reg >> 13);
                mb = xxh_pkg::PRIME_C;
            end
            default:
            begin
                ma = cmd.operand;
                mb = xxh_pkg::PRIME_B;
            end
        endcase
    end

    // one multiplier per lane, shared by every multiply, round, fold and avalanche step
    assign prod = ma * mb;

    // merge of the stripe accumulators, or the no-stripe start value
    assign base = cmd.seen ? (xxh_pkg::rotl(acc_reg[0], 1) + xxh_pkg::rotl(acc_reg[1], 7)
                            + xxh_pkg::rotl(acc_reg[2], 12) + xxh_pkg::rotl(acc_reg[3], 18))
                           : (seed + xxh_pkg::PRIME_E);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            xxh_pkg::OP_LOAD:
            begin
                acc_reg[0] <= seed + xxh_pkg::PRIME_A + xxh_pkg::PRIME_B;
                acc_reg[1] <= seed + xxh_pkg::PRIME_B;
                acc_reg[2] <= seed;
                acc_reg[3] <= seed - xxh_pkg::PRIME_A;
            end
            xxh_pkg::OP_MULB, xxh_pkg::OP_MULC, xxh_pkg::OP_MULE:
                prod_reg <= prod;
            xxh_pkg::OP_ACC:
                acc_reg[cmd.kidx] <= prod;
            xxh_pkg::OP_FOLDW, xxh_pkg::OP_FOLDB, xxh_pkg::OP_AV1, xxh_pkg::OP_AV2:
                h_reg <= prod;
            xxh_pkg::OP_INIT:
                h_reg <= base + cmd.len;
            default:
            begin
            end
        endcase
    end

    assign digest = h_reg ^ (h_reg >> 16);

endmodule

// ===== rtl/xxh_checker.sv =====
module xxh_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("request taken during digest finish");

    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without finish sequence");

endmodule

bind multi_seed_xxh32_hash_unit xxh_checker u_xxh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
